/* rtl/cps_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// cps_pkg
// Shared types, command codes and reset patterns of the chime sequencer.
// ============================================================================
package cps_pkg;

    localparam int unsigned NUM_CHIMES_DEF = 4;
    localparam int unsigned TIME_BITS_DEF  = 10;
    localparam int unsigned NUM_REGS       = 4;
    localparam int unsigned REG_IDX_W      = 2;
    localparam int unsigned ACTION_W       = 2;
    localparam int unsigned CHIME_W        = 2;
    localparam int unsigned QUEUE_DEPTH    = 2;

    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP  = 2'd2;

    localparam logic [63:0] CH0_ON   = 64'd5;
    localparam logic [63:0] CH0_GAP  = 64'd5;
    localparam logic [63:0] CH1_ON   = 64'd60;
    localparam logic [63:0] CH1_GAP  = 64'd90;
    localparam logic [63:0] CH1_REPS = 64'd20;
    localparam logic [63:0] CH2_ON   = 64'd5;
    localparam logic [63:0] CH2_GAP  = 64'd5;
    localparam logic [63:0] CH2_REPS = 64'd9;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_START,
        OP_STOP
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHIME_W-1:0] chan;
    } t_cmd;

    function automatic logic [63:0] pattern_reset(int unsigned idx, int unsigned tb);
        logic [63:0] v;
        v = 64'd0;
        if (idx == 0) begin
            v = (64'd1 << (3 * tb)) | (CH0_GAP << tb) | CH0_ON;
        end else if (idx == 1) begin
            v = (CH1_REPS << (2 * tb)) | (CH1_GAP << tb) | CH1_ON;
        end else if (idx == 2) begin
            v = (CH2_REPS << (2 * tb)) | (CH2_GAP << tb) | CH2_ON;
        end
        return v;
    endfunction

endpackage

/* rtl/cps_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// cps_front
// Input stage: takes words, drops meaningless ones and queues commands.
// ============================================================================
module cps_front #(
    parameter int unsigned NUM_CHIMES = cps_pkg::NUM_CHIMES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [cps_pkg::ACTION_W-1:0] i_action,
    input  logic [cps_pkg::CHIME_W-1:0]  i_chime,
    input  logic                         i_full,
    output logic                         o_push,
    output cps_pkg::t_cmd                o_cmd
);
    import cps_pkg::*;

    logic  r_vld;
    t_cmd  r_cmd;
    t_cmd  w_cmd;
    logic  w_keep;
    logic  w_known;

    always_comb begin
        w_cmd.chan = i_chime;
        w_known    = 1'b1;
        unique case (i_action)
            ACT_TICK:  w_cmd.op = OP_TICK;
            ACT_START: w_cmd.op = OP_START;
            ACT_STOP:  w_cmd.op = OP_STOP;
            default: begin
                w_cmd.op = OP_TICK;
                w_known  = 1'b0;
            end
        endcase
        w_keep = w_known && ((w_cmd.op == OP_TICK) || (32'(i_chime) < NUM_CHIMES));
    end

    assign o_push  = r_vld && !i_full;
    assign o_ready = !r_vld || !i_full;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_vld <= w_keep;
            r_cmd <= w_cmd;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

endmodule

/* rtl/cps_fifo.sv */
`timescale 1ns / 1ps
// ============================================================================
// cps_fifo
// Short command queue between the input stage and the sequencer.
// ============================================================================
module cps_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cps_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output cps_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);
    import cps_pkg::*;

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [CNTW-1:0] r_cnt;

    assign o_full  = (r_cnt == CNTW'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == LAST_SLOT) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == LAST_SLOT) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/cps_rem.sv */
`timescale 1ns / 1ps
// ============================================================================
// cps_rem
// Restoring remainder unit, one dividend bit per cycle.
// ============================================================================
module cps_rem #(
    parameter int unsigned DW = 2 * cps_pkg::TIME_BITS_DEF + 2,
    parameter int unsigned SW = cps_pkg::TIME_BITS_DEF + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [SW-1:0] i_divisor,
    output logic          o_done,
    output logic [SW-1:0] o_rem
);
    import cps_pkg::*;

    localparam int unsigned CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_dvd;
    logic [SW-1:0] r_div;
    logic [SW-1:0] r_rem;
    logic [SW:0]   w_shift;
    logic [SW:0]   w_diff;
    logic          w_ge;

    always_comb begin
        w_shift = {r_rem, r_dvd[DW-1]};
        w_ge    = (w_shift >= {1'b0, r_div});
        w_diff  = w_shift - {1'b0, r_div};
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[SW-1:0] : w_shift[SW-1:0];
                r_dvd <= {r_dvd[DW-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/cps_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// cps_back
// Sequencer: holds patterns and channel state, runs commands, emits events.
// ============================================================================
module cps_back #(
    parameter int unsigned NUM_CHIMES = cps_pkg::NUM_CHIMES_DEF,
    parameter int unsigned TIME_BITS  = cps_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cps_pkg::REG_IDX_W-1:0] i_cfg_idx,
    input  logic [3*TIME_BITS:0]          i_cfg_wdata,
    input  logic                          i_empty,
    input  cps_pkg::t_cmd                 i_cmd,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [cps_pkg::CHIME_W-1:0]   o_channel,
    output logic                          o_sound_on,
    output logic                          o_last
);
    import cps_pkg::*;

    localparam int unsigned T     = TIME_BITS;
    localparam int unsigned PW    = 3 * T + 1;
    localparam int unsigned PRW   = T + 1;
    localparam int unsigned EW    = 2 * T + 2;
    localparam int unsigned PRODW = PRW + T;
    localparam int unsigned CIW   = (NUM_CHIMES > 1) ? $clog2(NUM_CHIMES) : 1;
    localparam logic [EW-1:0]  ELAPSED_MAX = '1;
    localparam logic [CIW-1:0] LAST_CH     = CIW'(NUM_CHIMES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD,
        S_LOAD,
        S_MUL,
        S_CHECK,
        S_DIV,
        S_APPLY,
        S_FLUSH
    } t_state;

    logic [PW-1:0] w_pattern [NUM_CHIMES];

    for (genvar c = 0; c < NUM_CHIMES; c++) begin : g_pat
        if (c < NUM_REGS) begin : g_reg
            logic [PW-1:0] r_pat;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_pat <= PW'(pattern_reset(c, T));
                end else if (i_cfg_we && (i_cfg_idx == REG_IDX_W'(c))) begin
                    r_pat <= i_cfg_wdata;
                end
            end
            assign w_pattern[c] = r_pat;
        end else begin : g_zero
            assign w_pattern[c] = '0;
        end
    end

    t_state              r_state;
    t_op                 r_op;
    logic [CIW-1:0]      r_c;
    logic [NUM_CHIMES-1:0] r_armed;
    logic [NUM_CHIMES-1:0] r_sounding;
    logic [EW-1:0]       r_elapsed [NUM_CHIMES];
    logic [T-1:0]        r_on;
    logic [T-1:0]        r_reps;
    logic                r_forever;
    logic [PRW-1:0]      r_period;
    logic [PRODW-1:0]    r_prod;
    logic [EW-1:0]       r_elap;
    logic [PRW-1:0]      r_phase;
    logic                r_pend_vld;
    logic [CHIME_W-1:0]  r_pend_ch;
    logic                r_pend_on;
    logic                r_out_vld;
    logic [CHIME_W-1:0]  r_out_ch;
    logic                r_out_on;
    logic                r_out_last;

    logic [PW-1:0]  w_pat;
    logic           w_out_free;
    logic           w_can_emit;
    logic           w_over;
    logic           w_short;
    logic           w_hit_on;
    logic           w_evt;
    logic [EW-1:0]  w_base;
    logic [EW-1:0]  w_next_elap;
    logic           w_emit;
    logic           w_emit_on;
    logic           w_flush;
    logic           w_div_start;
    logic           w_div_done;
    logic [PRW-1:0] w_rem;

    cps_rem #(
        .DW (EW),
        .SW (PRW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_elap),
        .i_divisor  (r_period),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    always_comb begin
        w_pat       = w_pattern[r_c];
        w_out_free  = !r_out_vld || i_ready;
        w_can_emit  = !r_pend_vld || w_out_free;
        w_over      = (r_period == '0) || (!r_forever && (r_elap > EW'(r_prod)));
        w_short     = (r_elap < EW'(r_period));
        w_div_start = (r_state == S_CHECK) && !w_over && !w_short;
        w_hit_on    = (r_phase < {1'b0, r_on});
        w_evt       = (w_hit_on && !r_sounding[r_c]) || (!w_hit_on && r_sounding[r_c]);
        w_base      = r_forever ? EW'(r_phase) : r_elap;
        w_next_elap = (w_base == ELAPSED_MAX) ? w_base : w_base + EW'(1);
        o_pop       = (r_state == S_IDLE) && !i_empty;
        w_emit      = 1'b0;
        w_emit_on   = 1'b0;
        w_flush     = 1'b0;
        unique case (r_state)
            S_CMD: begin
                if (r_op == OP_STOP) begin
                    w_emit = w_can_emit;
                end else if (!r_armed[r_c]) begin
                    w_emit    = w_can_emit;
                    w_emit_on = 1'b1;
                end
            end
            S_CHECK: begin
                w_emit = w_over && w_can_emit;
            end
            S_APPLY: begin
                w_emit    = w_evt && w_can_emit;
                w_emit_on = w_hit_on;
            end
            S_FLUSH: begin
                w_flush = r_pend_vld && w_out_free;
            end
            default: begin
            end
        endcase
    end

    assign o_valid    = r_out_vld;
    assign o_channel  = r_out_ch;
    assign o_sound_on = r_out_on;
    assign o_last     = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_c        <= '0;
            r_armed    <= '0;
            r_sounding <= '0;
            for (int i = 0; i < NUM_CHIMES; i++) begin
                r_elapsed[i] <= '0;
            end
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_op <= i_cmd.op;
                        if (i_cmd.op == OP_TICK) begin
                            r_c     <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_c     <= CIW'(i_cmd.chan);
                            r_state <= S_CMD;
                        end
                    end
                end
                S_CMD: begin
                    if (r_op != OP_STOP && r_armed[r_c]) begin
                        r_state <= S_FLUSH;
                    end else if (w_emit) begin
                        r_armed[r_c]    <= w_emit_on;
                        r_sounding[r_c] <= w_emit_on;
                        r_elapsed[r_c]  <= '0;
                        r_state         <= S_FLUSH;
                    end
                end
                S_LOAD: begin
                    if (!r_armed[r_c]) begin
                        if (r_c == LAST_CH) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_c <= r_c + 1'b1;
                        end
                    end else begin
                        r_on      <= w_pat[T-1:0];
                        r_period  <= {1'b0, w_pat[T-1:0]} + {1'b0, w_pat[2*T-1:T]};
                        r_reps    <= w_pat[3*T-1:2*T];
                        r_forever <= w_pat[3*T];
                        r_elap    <= r_elapsed[r_c];
                        r_state   <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= PRODW'(r_period) * PRODW'(r_reps);
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (w_over) begin
                        if (w_emit) begin
                            r_armed[r_c]    <= 1'b0;
                            r_sounding[r_c] <= 1'b0;
                            r_elapsed[r_c]  <= '0;
                            if (r_c == LAST_CH) begin
                                r_state <= S_FLUSH;
                            end else begin
                                r_c     <= r_c + 1'b1;
                                r_state <= S_LOAD;
                            end
                        end
                    end else if (w_short) begin
                        r_phase <= PRW'(r_elap);
                        r_state <= S_APPLY;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_phase <= w_rem;
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (!w_evt || w_emit) begin
                        r_elapsed[r_c] <= w_next_elap;
                        if (w_evt) begin
                            r_sounding[r_c] <= w_hit_on;
                        end
                        if (r_c == LAST_CH) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_c     <= r_c + 1'b1;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_vld || w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_flush) begin
                r_out_vld  <= 1'b1;
                r_out_ch   <= r_pend_ch;
                r_out_on   <= r_pend_on;
                r_out_last <= 1'b1;
                r_pend_vld <= 1'b0;
            end else if (w_emit && r_pend_vld) begin
                r_out_vld  <= 1'b1;
                r_out_ch   <= r_pend_ch;
                r_out_on   <= r_pend_on;
                r_out_last <= 1'b0;
            end else if (r_out_vld && i_ready) begin
                r_out_vld <= 1'b0;
            end
            if (w_emit) begin
                r_pend_vld <= 1'b1;
                r_pend_ch  <= CHIME_W'(r_c);
                r_pend_on  <= w_emit_on;
            end
        end
    end

endmodule

/* rtl/chime_pattern_sequencer.sv */
`timescale 1ns / 1ps
// ============================================================================
// chime_pattern_sequencer
// Multi-channel chime sequencer with start, stop and tick commands.
// ============================================================================
// A start or stop word passes the input register and the command queue, and
// the sequencer stages its event until the flush state. A tick steps through
// every channel; for an armed one it loads the pattern, forms the repetition
// product, and runs the bit-serial remainder unit unless elapsed < period.
// Two queued commands and an input register let words arrive while one runs.
// Synchronous active-low reset idles all channels and reloads default patterns.
module chime_pattern_sequencer #(
    parameter int unsigned NUM_CHIMES = cps_pkg::NUM_CHIMES_DEF,
    parameter int unsigned TIME_BITS  = cps_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [cps_pkg::ACTION_W-1:0]  i_action,
    input  logic [cps_pkg::CHIME_W-1:0]   i_chime,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [cps_pkg::CHIME_W-1:0]   o_channel,
    output logic                          o_sound_on,
    output logic                          o_last,
    input  logic                          i_cfg_we,
    input  logic [cps_pkg::REG_IDX_W-1:0] i_cfg_idx,
    input  logic [3*TIME_BITS:0]          i_cfg_wdata
);
    import cps_pkg::*;

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_cmd w_in_cmd;
    t_cmd w_q_cmd;

    cps_front #(
        .NUM_CHIMES (NUM_CHIMES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_action (i_action),
        .i_chime  (i_chime),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_cmd    (w_in_cmd)
    );

    cps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_in_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    cps_back #(
        .NUM_CHIMES (NUM_CHIMES),
        .TIME_BITS  (TIME_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_empty     (w_empty),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_channel   (o_channel),
        .o_sound_on  (o_sound_on),
        .o_last      (o_last)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("Command pushed into a full queue.");

    a_queue_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_full && w_empty))
        else $error("Command queue reports full and empty at once.");

    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("Output word valid right after reset.");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking testbench for the chime pattern sequencer.
// ============================================================================
// Start, stop, tick and unused words are sent with random gaps. The event
// channel is stalled at random. Every sound edge that the block reports is
// compared, field by field, with the edge that a local copy of the channel
// state predicts. The run covers the reset patterns, extreme pattern
// registers, and several phases of random patterns with random command mixes.
// ============================================================================
module tb_top;
    import cps_pkg::*;

    localparam int unsigned TBITS     = TIME_BITS_DEF;
    localparam int unsigned NCH       = NUM_CHIMES_DEF;
    localparam int unsigned PAT_W     = 3 * TBITS + 1;
    localparam int unsigned ELAPSED_W = 2 * TBITS + 2;

    localparam logic [ACTION_W-1:0]  ACT_UNUSED = 2'd3;
    localparam logic [REG_IDX_W-1:0] REG_CHIME0 = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CHIME1 = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CHIME2 = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_CHIME3 = 2'd3;

    localparam int unsigned SETTLE_CYCLES   = 600;
    localparam int unsigned RANDOM_PHASES   = 6;
    localparam int unsigned WORDS_PER_PHASE = 52;

    typedef struct packed {
        logic [CHIME_W-1:0] channel;
        logic               sound_on;
        logic               last;
    } t_sound_edge;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic [ACTION_W-1:0]    i_action;
    logic [CHIME_W-1:0]     i_chime;
    logic                   o_valid;
    logic                   i_ready;
    logic [CHIME_W-1:0]     o_channel;
    logic                   o_sound_on;
    logic                   o_last;
    logic                   i_cfg_we;
    logic [REG_IDX_W-1:0]   i_cfg_idx;
    logic [PAT_W-1:0]       i_cfg_wdata;

    logic [PAT_W-1:0]       pattern_reg [NCH];
    logic                   armed [NCH];
    logic                   sounding [NCH];
    logic [ELAPSED_W-1:0]   elapsed [NCH];
    t_sound_edge            expected_edges [$];
    int unsigned            errors;
    int unsigned            send_quiet;
    int unsigned            recv_quiet;

    chime_pattern_sequencer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_chime     (i_chime),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_channel   (o_channel),
        .o_sound_on  (o_sound_on),
        .o_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic halt_chime(input int unsigned c);
        armed[c]    = 1'b0;
        sounding[c] = 1'b0;
        elapsed[c]  = '0;
        expected_edges.push_back({CHIME_W'(c), 1'b0, 1'b0});
    endtask

    // Updates the channel state for one accepted word and queues its edges.
    task automatic predict_edges(input logic [ACTION_W-1:0] act,
                                 input logic [CHIME_W-1:0] ch);
        int unsigned      first;
        logic [TBITS-1:0] on_t;
        logic [TBITS-1:0] gap_t;
        logic [TBITS-1:0] reps;
        logic             forever_mode;
        int unsigned      period;
        int unsigned      phase;
        t_sound_edge      tail;
        first = expected_edges.size();
        if (act == ACT_START) begin
            if (!armed[ch]) begin
                armed[ch]    = 1'b1;
                sounding[ch] = 1'b1;
                elapsed[ch]  = '0;
                expected_edges.push_back({ch, 1'b1, 1'b0});
            end
        end else if (act == ACT_STOP) begin
            halt_chime(ch);
        end else if (act == ACT_TICK) begin
            for (int unsigned c = 0; c < NCH; c++) begin
                if (armed[c]) begin
                    on_t         = pattern_reg[c][TBITS-1:0];
                    gap_t        = pattern_reg[c][2*TBITS-1:TBITS];
                    reps         = pattern_reg[c][3*TBITS-1:2*TBITS];
                    forever_mode = pattern_reg[c][3*TBITS];
                    period       = on_t + gap_t;
                    if (period == 0 || (!forever_mode && elapsed[c] > period * reps)) begin
                        halt_chime(c);
                    end else begin
                        phase = elapsed[c] % period;
                        if (forever_mode) begin
                            elapsed[c] = ELAPSED_W'(phase);
                        end
                        if (phase < on_t && !sounding[c]) begin
                            sounding[c] = 1'b1;
                            expected_edges.push_back({CHIME_W'(c), 1'b1, 1'b0});
                        end else if (phase >= on_t && sounding[c]) begin
                            sounding[c] = 1'b0;
                            expected_edges.push_back({CHIME_W'(c), 1'b0, 1'b0});
                        end
                        if (elapsed[c] != '1) begin
                            elapsed[c] = elapsed[c] + 1'b1;
                        end
                    end
                end
            end
        end
        if (expected_edges.size() > first) begin
            tail      = expected_edges.pop_back();
            tail.last = 1'b1;
            expected_edges.push_back(tail);
        end
    endtask

    task automatic send_word(input logic [ACTION_W-1:0] act, input logic [CHIME_W-1:0] ch);
        int unsigned gap;
        if (send_quiet > 0) begin
            send_quiet--;
            gap = 0;
        end else if ($urandom_range(0, 19) == 0) begin
            send_quiet = $urandom_range(8, 30);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 15);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_chime  <= ch;
        do @(posedge i_clk); while (!o_ready);
        predict_edges(act, ch);
    endtask

    task automatic write_pattern(input logic [REG_IDX_W-1:0] idx,
                                 input logic [PAT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        pattern_reg[idx] = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // A tick that reports nothing may still be running when the queue empties.
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_edges.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [PAT_W-1:0] random_pattern();
        logic [PAT_W-1:0] p;
        p = '0;
        case ($urandom_range(0, 9))
            0: p = PAT_W'($urandom);
            1: p = '0;
            default: begin
                p[TBITS-1:0]         = TBITS'($urandom_range(0, 4));
                p[2*TBITS-1:TBITS]   = TBITS'($urandom_range(0, 4));
                p[3*TBITS-1:2*TBITS] = TBITS'($urandom_range(0, 3));
                p[3*TBITS]           = ($urandom_range(0, 3) == 0);
            end
        endcase
        return p;
    endfunction

    task automatic test_reset_patterns();
        send_word(ACT_START, 2'd0);
        send_word(ACT_START, 2'd1);
        send_word(ACT_START, 2'd2);
        send_word(ACT_START, 2'd3);
        send_word(ACT_START, 2'd1);
        send_word(ACT_UNUSED, 2'd2);
        send_word(ACT_TICK, 2'd3);
        send_word(ACT_STOP, 2'd3);
        repeat (5) send_word(ACT_TICK, CHIME_W'($urandom_range(0, 3)));
        send_word(ACT_STOP, 2'd1);
    endtask

    task automatic test_pattern_extremes();
        settle();
        write_pattern(REG_CHIME0, '1);
        write_pattern(REG_CHIME1, {1'b0, 10'd0, 10'd1, 10'd0});
        write_pattern(REG_CHIME2, {1'b0, 10'd1, 10'd0, 10'd1});
        write_pattern(REG_CHIME3, {1'b1, 10'd0, 10'd1, 10'd2});
        send_word(ACT_START, 2'd1);
        send_word(ACT_START, 2'd3);
        repeat (4) send_word(ACT_TICK, 2'd2);
        send_word(ACT_STOP, 2'd0);
        send_word(ACT_STOP, 2'd2);
    endtask

    task automatic test_random_phases();
        int unsigned pick;
        for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            for (int unsigned r = 0; r < NUM_REGS; r++) begin
                write_pattern(REG_IDX_W'(r), random_pattern());
            end
            for (int unsigned n = 0; n < WORDS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 62) begin
                    send_word(ACT_TICK, CHIME_W'($urandom_range(0, 3)));
                end else if (pick < 82) begin
                    send_word(ACT_START, CHIME_W'($urandom_range(0, 3)));
                end else if (pick < 94) begin
                    send_word(ACT_STOP, CHIME_W'($urandom_range(0, 3)));
                end else begin
                    send_word(ACT_UNUSED, CHIME_W'($urandom_range(0, 3)));
                end
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_action    = ACT_TICK;
        i_chime     = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_CHIME0;
        i_cfg_wdata = '0;
        errors      = 0;
        send_quiet  = 0;
        pattern_reg[0] = {1'b1, 10'd0, 10'd5, 10'd5};
        pattern_reg[1] = {1'b0, 10'd20, 10'd90, 10'd60};
        pattern_reg[2] = {1'b0, 10'd9, 10'd5, 10'd5};
        pattern_reg[3] = '0;
        for (int unsigned c = 0; c < NCH; c++) begin
            armed[c]    = 1'b0;
            sounding[c] = 1'b0;
            elapsed[c]  = '0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_patterns();
        test_pattern_extremes();
        test_random_phases();

        settle();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        int unsigned stall;
        i_ready    = 1'b0;
        recv_quiet = 0;
        forever begin
            if (recv_quiet > 0) begin
                recv_quiet--;
                stall = 0;
            end else if ($urandom_range(0, 19) == 0) begin
                recv_quiet = $urandom_range(8, 30);
                stall = 0;
            end else begin
                stall = $urandom_range(0, 15);
            end
            @(negedge i_clk);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin : check_edges
        t_sound_edge want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_edges.size() == 0) begin
                $display("%0t: expected no word, actual channel %0d sound_on %0b last %0b",
                         $time, o_channel, o_sound_on, o_last);
                errors++;
            end else begin
                want = expected_edges.pop_front();
                if (o_channel !== want.channel) begin
                    $display("%0t: channel expected %0d actual %0d",
                             $time, want.channel, o_channel);
                    errors++;
                end
                if (o_sound_on !== want.sound_on) begin
                    $display("%0t: sound_on expected %0b actual %0b",
                             $time, want.sound_on, o_sound_on);
                    errors++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last expected %0b actual %0b",
                             $time, want.last, o_last);
                    errors++;
                end
            end
        end
    end

endmodule

/* chime_pattern_sequencer.f */
rtl/cps_pkg.sv
rtl/cps_front.sv
rtl/cps_fifo.sv
rtl/cps_rem.sv
rtl/cps_back.sv
rtl/chime_pattern_sequencer.sv
sim/tb_top.sv
